// ===== hw/rtl/multi_button_event_debouncer_core_macros.svh =====
// Assertion helpers for the button qualifier.
`ifndef MULTI_BUTTON_EVENT_DEBOUNCER_CORE_MACROS_SVH
`define MULTI_BUTTON_EVENT_DEBOUNCER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define MBD_ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define MBD_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("assertion failed");
`else
`define MBD_ASSERT_IMPL(label, clk, rst_n, prop)
`define MBD_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== hw/rtl/mbd_pkg.sv =====
package mbd_pkg;
  localparam int unsigned MaxChannels = 32;
  localparam int unsigned LaneCount = 8;
  localparam logic [1:0] ModeScan = 2'd0;
  localparam logic [1:0] ModeDrain = 2'd1;
  localparam logic [1:0] ModeClear = 2'd2;
  localparam logic [1:0] ModeNone = 2'd3;
  localparam logic [2:0] CfgInvert = 3'd0;
  localparam logic [2:0] CfgDebounce = 3'd1;
  localparam logic [2:0] CfgDouble = 3'd2;
  localparam logic [2:0] CfgLong = 3'd3;
  localparam logic [2:0] CfgRptDelay = 3'd4;
  localparam logic [2:0] CfgRptIntv = 3'd5;
  localparam logic [2:0] CfgChanCount = 3'd6;
  localparam logic [4:0] EvPressed = 5'd1;
  localparam logic [4:0] EvReleased = 5'd2;
  localparam logic [4:0] EvDouble = 5'd4;
  localparam logic [4:0] EvLong = 5'd8;
  localparam logic [4:0] EvRepeat = 5'd16;

  typedef struct packed {
    logic        invert;
    logic [15:0] debounce;
    logic [15:0] dbl_win;
    logic [15:0] long_time;
    logic [15:0] rpt_delay;
    logic [15:0] rpt_intv;
  } cfg_t;

  typedef struct packed {
    logic        stable;
    logic        long_done;
    logic [4:0]  flags;
    logic [31:0] change;
    logic [31:0] press;
    logic [31:0] repeat_ts;
    logic [31:0] release_ts;
  } chan_t;
endpackage

// ===== hw/rtl/multi_button_event_debouncer_core.sv =====
// Multi-channel button qualifier with a stream input and a stream output.
// Input request: tuser = mode, tdata = raw_bits, now_ms and the event limit.
// mode scan updates all active channels and returns one result with the
// debounced vector. mode drain returns one result per channel with pending
// flags (up to the event limit), clearing them; otherwise one empty result.
// mode clear wipes pending flags of the active channels and returns one empty result.
// Channel records are processed by eight lanes side by side, one group of
// eight channels per cycle, and a scan result follows the last group. A
// drain walks one channel per cycle while the output register is free and
// puts out a result at each channel with pending flags; an empty drain
// presents its result once the walk has ended. A clear or an unused mode
// goes straight to the output state. The next request is taken only once
// the last result has been taken and the channel walk has finished. A
// result waits in the output register while the receiver stalls, and the
// drain walk pauses with it. Reset returns all channel state and registers
// to their defaults with no result pending. Configuration writes take
// effect immediately and are expected only while the block is idle.
`include "multi_button_event_debouncer_core_macros.svh"
module multi_button_event_debouncer_core #(
  parameter int unsigned CHANNELS = mbd_pkg::MaxChannels
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // raw_bits[31:0], now_ms[63:32], ev_limit[71:64]
  input  logic [71:0]  s_axis_tdata,
  // mode[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // channel_index[4:0], event_flags[9:5], event_time[41:10], hold_time[73:42],
  // debounced_vector[105:74], raw_vector[137:106], zero fill[143:138]
  output logic [143:0] m_axis_tdata,
  // has_event[0]
  output logic         m_axis_tuser,
  output logic         m_axis_tlast,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [15:0]  cfg_data_i
);
  localparam int unsigned Lanes = mbd_pkg::LaneCount;
  localparam int unsigned Groups = (CHANNELS + Lanes - 1) / Lanes;
  localparam int unsigned CW = $clog2(CHANNELS + 1);
  localparam int unsigned IW = $clog2(CHANNELS);

  typedef enum logic [1:0] {StIdle, StScan, StDrain, StOut} state_e;

  state_e state_q;
  mbd_pkg::cfg_t cfg_q;
  logic [5:0] ccount_q;
  mbd_pkg::chan_t rec_q [CHANNELS];
  mbd_pkg::chan_t lane_out [Lanes];
  logic [31:0] last_raw_q, last_time_q;
  logic [1:0]  mode_q;
  logic [31:0] now_q;
  logic [7:0]  max_q;
  logic [CW-1:0] idx_q, cnt_q, nact;
  logic        ov_q, olast_q, ohas_q;
  logic [4:0]  och_q, oflags_q;
  logic [31:0] otime_q, odur_q;
  logic [CHANNELS-1:0] stable_vec;
  logic [31:0] deb_vec;
  logic [CW-1:0] maxc;
  logic        emitted_q;
  logic        out_free, drain_hit, out_load, more_pend;

  assign nact = (ccount_q > 6'(CHANNELS)) ? CW'(CHANNELS) : CW'(ccount_q);
  assign maxc = (max_q > 8'(CHANNELS)) ? CW'(CHANNELS) : CW'(max_q);

  always_comb begin
    for (int k = 0; k < CHANNELS; k++) stable_vec[k] = rec_q[k].stable;
  end
  assign deb_vec = 32'(stable_vec);

  always_comb begin
    more_pend = 1'b0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (CW'(k) > idx_q && CW'(k) < nact && rec_q[k].flags != '0) more_pend = 1'b1;
    end
  end

  assign out_free = !ov_q || m_axis_tready;
  assign drain_hit = (state_q == StDrain) && (idx_q < nact) && (cnt_q < maxc) &&
                     (rec_q[IW'(idx_q)].flags != '0);
  assign out_load = out_free && ((state_q == StOut) || drain_hit);

  for (genvar l = 0; l < Lanes; l++) begin : g_lane
    logic [IW-1:0] ch;
    assign ch = IW'(idx_q * CW'(Lanes) + CW'(l));
    mbd_lane u_lane (
      .cfg_i(cfg_q), .rec_i(rec_q[ch]), .raw_i(last_raw_q[ch]),
      .now_i(now_q), .rec_o(lane_out[l])
    );
  end

  assign s_axis_tready = (state_q == StIdle) && !ov_q;
  assign m_axis_tvalid = ov_q;
  assign m_axis_tlast = olast_q;
  assign m_axis_tuser = ohas_q;
  assign m_axis_tdata = {6'd0, last_raw_q, deb_vec, odur_q, otime_q, oflags_q, och_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cfg_q <= '{1'b0, 16'd50, 16'd0, 16'd1000, 16'd500, 16'd100};
      ccount_q <= 6'd8;
      for (int k = 0; k < CHANNELS; k++) rec_q[k] <= '0;
      last_raw_q <= '0;
      last_time_q <= '0;
      ov_q <= 1'b0;
      olast_q <= 1'b0;
      idx_q <= '0;
      cnt_q <= '0;
      emitted_q <= 1'b0;
      mode_q <= '0;
      now_q <= '0;
      max_q <= '0;
      ohas_q <= 1'b0;
      och_q <= '0;
      oflags_q <= '0;
      otime_q <= '0;
      odur_q <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          mbd_pkg::CfgInvert:    cfg_q.invert <= cfg_data_i[0];
          mbd_pkg::CfgDebounce:  cfg_q.debounce <= cfg_data_i;
          mbd_pkg::CfgDouble:    cfg_q.dbl_win <= cfg_data_i;
          mbd_pkg::CfgLong:      cfg_q.long_time <= cfg_data_i;
          mbd_pkg::CfgRptDelay:  cfg_q.rpt_delay <= cfg_data_i;
          mbd_pkg::CfgRptIntv:   cfg_q.rpt_intv <= cfg_data_i;
          mbd_pkg::CfgChanCount: ccount_q <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      if (out_load) ov_q <= 1'b1;
      else if (m_axis_tready) ov_q <= 1'b0;
      case (state_q)
        StIdle: begin
          if (s_axis_tvalid && !ov_q) begin
            mode_q <= s_axis_tuser;
            now_q <= s_axis_tdata[63:32];
            max_q <= s_axis_tdata[71:64];
            idx_q <= '0;
            cnt_q <= '0;
            emitted_q <= 1'b0;
            case (s_axis_tuser)
              mbd_pkg::ModeScan: begin
                last_raw_q <= s_axis_tdata[31:0];
                last_time_q <= s_axis_tdata[63:32];
                state_q <= StScan;
              end
              mbd_pkg::ModeDrain: state_q <= StDrain;
              mbd_pkg::ModeClear: begin
                for (int k = 0; k < CHANNELS; k++)
                  if (CW'(k) < nact) rec_q[k].flags <= '0;
                state_q <= StOut;
              end
              default: state_q <= StOut;
            endcase
          end
        end
        StScan: begin
          for (int l = 0; l < Lanes; l++) begin
            if (idx_q * CW'(Lanes) + CW'(l) < nact &&
                idx_q * CW'(Lanes) + CW'(l) < CW'(CHANNELS))
              rec_q[IW'(idx_q * CW'(Lanes) + CW'(l))] <= lane_out[l];
          end
          if (idx_q == CW'(Groups - 1)) state_q <= StOut;
          else idx_q <= idx_q + CW'(1);
        end
        StDrain: begin
          if (out_free) begin
            if (idx_q >= nact || cnt_q >= maxc) begin
              if (!emitted_q) state_q <= StOut;
              else begin
                // Final pending result was already flagged last.
                state_q <= StIdle;
              end
            end else begin
              if (drain_hit) begin
                ohas_q <= 1'b1;
                och_q <= 5'(idx_q);
                oflags_q <= rec_q[IW'(idx_q)].flags;
                otime_q <= last_time_q;
                odur_q <= (rec_q[IW'(idx_q)].press != '0) ?
                          last_time_q - rec_q[IW'(idx_q)].press : '0;
                rec_q[IW'(idx_q)].flags <= '0;
                cnt_q <= cnt_q + CW'(1);
                emitted_q <= 1'b1;
                olast_q <= !(more_pend && (cnt_q + CW'(1) < maxc));
              end
              idx_q <= idx_q + CW'(1);
            end
          end
        end
        StOut: begin
          if (out_free) begin
            ohas_q <= 1'b0;
            och_q <= '0;
            oflags_q <= '0;
            otime_q <= (mode_q == mbd_pkg::ModeScan) ? now_q : last_time_q;
            odur_q <= '0;
            olast_q <= 1'b1;
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  `MBD_ASSERT_NEVER(a_no_accept_busy, clk_i, rst_ni, s_axis_tready && state_q != StIdle)
  `MBD_ASSERT_IMPL(a_empty_last, clk_i, rst_ni, (m_axis_tvalid && !m_axis_tuser) |-> m_axis_tlast)
  `MBD_ASSERT_NEVER(a_event_flags, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser && m_axis_tdata[9:5] == 5'd0)
endmodule

// ===== hw/rtl/mbd_lane.sv =====
module mbd_lane (
  input  mbd_pkg::cfg_t  cfg_i,
  input  mbd_pkg::chan_t rec_i,
  input  logic           raw_i,
  input  logic [31:0]    now_i,
  output mbd_pkg::chan_t rec_o
);
  logic        cur;
  logic [31:0] dur;
  mbd_pkg::chan_t r;

  always_comb begin
    r = rec_i;
    cur = raw_i ^ cfg_i.invert;
    if (cur != rec_i.stable) begin
      if ((now_i - rec_i.change) >= {16'd0, cfg_i.debounce}) begin
        r.stable = cur;
        r.change = now_i;
        if (cur) begin
          r.flags = r.flags | mbd_pkg::EvPressed;
          r.press = now_i;
          r.long_done = 1'b0;
          r.repeat_ts = now_i;
          if (cfg_i.dbl_win != 16'd0 &&
              (now_i - rec_i.release_ts) < {16'd0, cfg_i.dbl_win}) begin
            r.flags = r.flags | mbd_pkg::EvDouble;
          end
        end else begin
          r.flags = r.flags | mbd_pkg::EvReleased;
          r.release_ts = now_i;
          r.press = '0;
        end
      end
    end else begin
      r.change = now_i;
    end
    dur = now_i - r.press;
    if (r.stable && r.press != '0) begin
      if (!r.long_done && dur >= {16'd0, cfg_i.long_time}) begin
        r.flags = r.flags | mbd_pkg::EvLong;
        r.long_done = 1'b1;
      end
      if (dur >= {16'd0, cfg_i.rpt_delay} &&
          (now_i - r.repeat_ts) >= {16'd0, cfg_i.rpt_intv}) begin
        r.flags = r.flags | mbd_pkg::EvRepeat;
        r.repeat_ts = now_i;
      end
    end
    rec_o = r;
  end
endmodule
